// ===== rtl/ngh_pkg.sv =====
// Shared types, constants and helper functions for the character n-gram histogram.
package ngh_pkg;

   localparam int DEF_WINDOW_LEN  = 3;
   localparam int DEF_COUNT_WIDTH = 32;

   localparam int RADIX       = 27;
   localparam int CODE_W      = 5;
   localparam int CHAR_W      = 8;
   localparam int IDX_W       = 15;
   localparam int COUNT_OUT_W = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CHAR_W-1:0] CHAR_A       = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_Z       = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum logic {
      CMD_INC  = 1'b0,
      CMD_READ = 1'b1
   } cmd_kind_type;

   // 27^w: table depth for a window of w letters, also the weight of slot w
   function automatic int table_size(int w);
      int s = 1;
      for (int i = 0; i < w; i++) begin
         s = s * RADIX;
      end
      return s;
   endfunction

   function automatic int addr_width(int w);
      return $clog2(table_size(w));
   endfunction

   // kind + in_range + address + echoed read index
   function automatic int cmd_width(int w);
      return 2 + addr_width(w) + IDX_W;
   endfunction

endpackage

// ===== rtl/ngh_if.sv =====
// Valid/ready channel interfaces for the request and response streams.
interface ngh_req_if;
   import ngh_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [CHAR_W-1:0] char_byte;
   logic [IDX_W-1:0]  read_index;

   modport source (output valid, action, char_byte, read_index, input ready);
   modport sink   (input valid, action, char_byte, read_index, output ready);
endinterface

interface ngh_rsp_if;
   import ngh_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [COUNT_OUT_W-1:0] count;
   logic [IDX_W-1:0]       count_index;

   modport source (output valid, count, count_index, input ready);
   modport sink   (input valid, count, count_index, output ready);
endinterface

// ===== rtl/ngh_front.sv =====
// Front end: letter window, byte classification and command generation.
module ngh_front #(
   parameter  int WINDOW_LEN = ngh_pkg::DEF_WINDOW_LEN,
   localparam int CMD_W      = ngh_pkg::cmd_width(WINDOW_LEN)
) (
   input  logic             clock,
   input  logic             reset,
   ngh_req_if.sink          req_ch,
   input  logic             hold,
   input  logic             q_full,
   output logic             q_push,
   output logic [CMD_W-1:0] q_data
);
   import ngh_pkg::*;

   localparam int ADDR_W     = addr_width(WINDOW_LEN);
   localparam int TABLE_SIZE = table_size(WINDOW_LEN);

   typedef struct packed {
      cmd_kind_type      kind;
      logic              in_range;
      logic [ADDR_W-1:0] addr;
      logic [IDX_W-1:0]  read_index;
   } cmd_type;

   logic [CODE_W-1:0] codes_ff [WINDOW_LEN];
   logic [CODE_W-1:0] codes_in [WINDOW_LEN];
   logic              bad_ff   [WINDOW_LEN];
   logic              bad_in   [WINDOW_LEN];

   logic              take;
   logic              is_newline;
   logic              is_letter;
   logic              full_window;
   logic [CODE_W-1:0] new_code;
   logic [ADDR_W-1:0] ngram_idx;
   cmd_type           cmd;

   assign req_ch.ready = !q_full && !hold;
   assign take         = req_ch.valid && req_ch.ready;

   assign is_newline = (req_ch.char_byte == CHAR_NEWLINE);
   assign is_letter  = (req_ch.char_byte >= CHAR_A) && (req_ch.char_byte <= CHAR_Z);
   assign new_code   = CODE_W'(req_ch.char_byte - CHAR_A + 8'd1);

   // next window
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         codes_in[i] = codes_ff[i];
         bad_in[i]   = bad_ff[i];
      end
      if (take && (req_ch.action == ACT_CHAR)) begin
         if (is_newline) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
               codes_in[i] = '0;
               bad_in[i]   = 1'b0;
            end
         end else begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
               codes_in[i] = codes_ff[i+1];
               bad_in[i]   = bad_ff[i+1];
            end
            codes_in[WINDOW_LEN-1] = is_letter ? new_code : '0;
            bad_in[WINDOW_LEN-1]   = !is_letter;
         end
      end
   end

   // base-27 index of the new window, oldest slot weighs 1
   always_comb begin
      ngram_idx   = '0;
      full_window = 1'b1;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         ngram_idx = ngram_idx + ADDR_W'(codes_in[i]) * ADDR_W'(table_size(i));
         if ((codes_in[i] == '0) || bad_in[i]) begin
            full_window = 1'b0;
         end
      end
   end

   always_comb begin
      cmd.read_index = req_ch.read_index;
      if (req_ch.action == ACT_READ) begin
         cmd.kind     = CMD_READ;
         cmd.in_range = (32'(req_ch.read_index) < 32'(TABLE_SIZE));
         cmd.addr     = ADDR_W'(req_ch.read_index);
      end else begin
         cmd.kind     = CMD_INC;
         cmd.in_range = 1'b1;
         cmd.addr     = ngram_idx;
      end
   end

   assign q_push = take && ((req_ch.action == ACT_READ) || (is_letter && full_window));
   assign q_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            codes_ff[i] <= '0;
            bad_ff[i]   <= 1'b0;
         end
      end else begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            codes_ff[i] <= codes_in[i];
            bad_ff[i]   <= bad_in[i];
         end
      end
   end

endmodule

// ===== rtl/ngh_queue.sv =====
// Short command queue between the front end and the counter back end.
module ngh_queue #(
   parameter int WIDTH = ngh_pkg::cmd_width(ngh_pkg::DEF_WINDOW_LEN)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   input  logic             pop
);
   import ngh_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_data  = slots_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + CNT_W'(1);
         2'b01:   fill_in = fill_ff - CNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/ngh_back.sv =====
// Back end: histogram memory, clearing pass, increment with forwarding, read results.
module ngh_back #(
   parameter  int WINDOW_LEN  = ngh_pkg::DEF_WINDOW_LEN,
   parameter  int COUNT_WIDTH = ngh_pkg::DEF_COUNT_WIDTH,
   localparam int CMD_W       = ngh_pkg::cmd_width(WINDOW_LEN)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  logic [CMD_W-1:0] head_data,
   output logic             pop,
   output logic             clearing,
   ngh_rsp_if.source        rsp_ch
);
   import ngh_pkg::*;

   localparam int ADDR_W     = addr_width(WINDOW_LEN);
   localparam int TABLE_SIZE = table_size(WINDOW_LEN);

   typedef struct packed {
      cmd_kind_type      kind;
      logic              in_range;
      logic [ADDR_W-1:0] addr;
      logic [IDX_W-1:0]  read_index;
   } cmd_type;

   logic [COUNT_WIDTH-1:0] mem [TABLE_SIZE];

   cmd_type                head;
   logic                   s1_valid_ff, s1_valid_in;
   cmd_type                s1_cmd_ff;
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   logic                   wr_valid_ff;
   logic [ADDR_W-1:0]      wr_addr_ff;
   logic [COUNT_WIDTH-1:0] wr_data_ff;

   logic                   clr_active_ff;
   logic [ADDR_W-1:0]      clr_addr_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic [IDX_W-1:0]       rsp_index_ff;

   logic                   s1_is_read;
   logic                   rsp_free;
   logic                   s1_advance;
   logic                   do_inc;
   logic                   rsp_load;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] inc_count;
   logic [63:0]            wide_count;
   logic [COUNT_OUT_W-1:0] sat_count;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   assign head     = cmd_type'(head_data);
   assign clearing = clr_active_ff;

   assign s1_is_read = (s1_cmd_ff.kind == CMD_READ);
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign s1_advance = !s1_valid_ff || !s1_is_read || rsp_free;
   assign pop        = head_valid && s1_advance && !clr_active_ff;
   assign s1_valid_in = s1_advance ? pop : s1_valid_ff;

   // last write is not yet visible through the registered read port
   assign cur_count = (wr_valid_ff && (wr_addr_ff == s1_cmd_ff.addr)) ? wr_data_ff : rd_data_ff;
   assign inc_count = (cur_count == {COUNT_WIDTH{1'b1}}) ? cur_count
                                                         : cur_count + COUNT_WIDTH'(1);

   assign wide_count = 64'(cur_count);
   assign sat_count  = (wide_count > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : wide_count[31:0];

   assign do_inc   = s1_valid_ff && !s1_is_read;
   assign rsp_load = s1_valid_ff && s1_is_read && rsp_free;

   assign mem_we    = clr_active_ff || do_inc;
   assign mem_waddr = clr_active_ff ? clr_addr_ff : s1_cmd_ff.addr;
   assign mem_wdata = clr_active_ff ? '0 : inc_count;

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.count       = rsp_count_ff;
   assign rsp_ch.count_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (pop && head.in_range) begin
         rd_data_ff <= mem[head.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_inc) begin
            wr_valid_ff <= 1'b1;
         end
         if (clr_active_ff) begin
            if (clr_addr_ff == ADDR_W'(TABLE_SIZE - 1)) begin
               clr_active_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_cmd_ff <= head;
      end
      if (do_inc) begin
         wr_addr_ff <= s1_cmd_ff.addr;
         wr_data_ff <= inc_count;
      end
      if (rsp_load) begin
         rsp_count_ff <= s1_cmd_ff.in_range ? sat_count : '0;
         rsp_index_ff <= s1_cmd_ff.read_index;
      end
   end

endmodule

// ===== rtl/char_ngram_histogram.sv =====
// Top level of the character n-gram histogram.
//
// req_ch carries one transfer per item: action 0 feeds char_byte into the
// letter window, action 1 asks for the counter at read_index. rsp_ch returns
// exactly one transfer per read action (count, count_index); character
// actions produce no response.
// Throughput: one request per cycle while req_ch.ready is high, including
// repeated n-grams back to back (the last counter write is forwarded around
// the memory). A read response passes through the command queue register,
// the registered memory read port and the response output register.
// After reset the histogram memory is swept to zero, one counter per cycle,
// all 27^WINDOW_LEN counters (19683 at the default window); req_ch.ready stays
// low for the whole sweep and the letter window starts empty.
// When rsp_ch stalls, the response holds in its output register; a second
// read then waits in the back stage, the 4-entry queue absorbs the next
// commands, and req_ch.ready drops only once the queue is full.
module char_ngram_histogram #(
   parameter int WINDOW_LEN  = ngh_pkg::DEF_WINDOW_LEN,
   parameter int COUNT_WIDTH = ngh_pkg::DEF_COUNT_WIDTH
) (
   input logic        clock,
   input logic        reset,
   ngh_req_if.sink    req_ch,
   ngh_rsp_if.source  rsp_ch
);
   import ngh_pkg::*;

   localparam int CMD_W = cmd_width(WINDOW_LEN);

   // front end -> queue
   logic             q_push;
   logic [CMD_W-1:0] q_push_data;
   logic             q_full;

   // queue -> back end
   logic             q_head_valid;
   logic [CMD_W-1:0] q_head_data;
   logic             q_pop;

   // back end still sweeping the memory
   logic             clearing;

   ngh_front #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .hold   (clearing),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   ngh_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop)
   );

   ngh_back #(
      .WINDOW_LEN  (WINDOW_LEN),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .clearing   (clearing),
      .rsp_ch     (rsp_ch)
   );

endmodule
